// ----- hw/rtl/circular_flash_log_write_allocator_assert.svh -----
// assertion macros for the circular flash log allocator
`ifndef CIRCULAR_FLASH_LOG_WRITE_ALLOCATOR_ASSERT_SVH
`define CIRCULAR_FLASH_LOG_WRITE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define CFLWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// next-cycle implication
`define CFLWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

// ----- hw/rtl/cflwa_pkg.sv -----
`timescale 1ns / 1ps
package cflwa_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int MAX_SECTORS  = 256;

    localparam int LEN_W   = 16;
    localparam int SB_W    = 17;
    localparam int SC_W    = 9;
    localparam int OFF_W   = 24;
    localparam int SEC_W   = 8;
    localparam int HEAD_W  = 25;
    localparam int NUM_W   = 26;
    localparam int QUOT_W  = 9;
    localparam int STEP_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [SB_W-1:0] SB_MIN   = SB_W'(16);
    localparam logic [SB_W-1:0] SB_MAX   = SB_W'(65536);
    localparam logic [SB_W-1:0] SB_RESET = SB_W'(4096);
    localparam logic [SC_W-1:0] SC_MIN   = SC_W'(1);
    localparam logic [SC_W-1:0] SC_MAX   = SC_W'(MAX_SECTORS);
    localparam logic [SC_W-1:0] SC_RESET = SC_W'(16);

    localparam logic [QUOT_W-1:0] QUOT_SAT  = QUOT_W'(256);
    localparam logic [STEP_W-1:0] STEP_TOP  = STEP_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_W,
        ST_DIV_E,
        ST_DIV_H,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] numer;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [SB_W-1:0]   rem;
    } t_div_rsp;

endpackage

// ----- hw/rtl/circular_flash_log_write_allocator.sv -----
`timescale 1ns / 1ps
// Write-pointer allocator for a circular log in erase-sector flash.
// Input channel: i_valid / o_stall carry one request, i_payload_length, the
// data bytes of a block to append (an 8-byte header is added internally).
// Output channel: o_valid / i_stall carry one result per request: accepted
// flag, write offset, erase command and sector, generation bit, tail sector
// and tail-moved flag.
// Configuration: i_cfg_wr_en with i_cfg_index (0 sector size, 1 sector count)
// and i_cfg_wdata; the user must write only while idle, as the block does not
// enforce this. Out-of-range values are clamped, the count after truncation
// to 9 bits. A rejected block needs no division; a placed block takes three
// passes through one shared restoring divider resolving one sector-index bit
// per cycle.
// One request is processed at a time; o_stall is high from acceptance until
// the result has been handed to the output register.
// The output register holds a result while i_stall is high; the next request
// may be accepted and processed meanwhile, and waits to deliver its result.
// Reset (synchronous, i_rst_n low) empties the log: head, tail, generation
// and tail-full flag clear, sector size returns to 4096 and count to 16.
module circular_flash_log_write_allocator
    import cflwa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SB_W-1:0]      i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [LEN_W-1:0]     i_payload_length,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_accepted,
    output logic [OFF_W-1:0]     o_place_offset,
    output logic                 o_erase_needed,
    output logic [SEC_W-1:0]     o_erase_index,
    output logic                 o_stamp_generation,
    output logic [SEC_W-1:0]     o_oldest_sector,
    output logic                 o_tail_moved
);

    t_state r_state;
    t_state n_state;

    logic [SB_W-1:0]   r_sector_bytes;
    logic [SC_W-1:0]   r_sector_count;
    logic [HEAD_W-1:0] r_head;
    logic [SEC_W-1:0]  r_tail;
    logic              r_gen;
    logic              r_tail_full;

    logic [SB_W-1:0]   r_size;
    logic              r_reject;
    logic [QUOT_W-1:0] r_wsec;
    logic [OFF_W-1:0]  r_woff;
    logic [SEC_W-1:0]  r_sec;
    logic              r_erase;
    logic              r_moved;

    t_div_req          w_req;
    t_div_rsp          w_rsp;

    logic [SB_W-1:0]   w_s_eff;
    logic [SC_W-1:0]   w_n_eff;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_too_big;
    logic [NUM_W-1:0]  w_end;
    logic              w_cross;
    logic [QUOT_W-1:0] w_sec0;
    logic [NUM_W-1:0]  w_off0;
    logic              w_wrap;
    logic [QUOT_W-1:0] w_sec;
    logic [NUM_W-1:0]  w_off;
    logic              w_erase;
    logic              w_moved;
    logic [QUOT_W-1:0] w_tail_inc;
    logic [SEC_W-1:0]  w_tail_nxt;
    logic [HEAD_W-1:0] w_head_new;

    cflwa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_divisor (w_s_eff),
        .o_rsp     (w_rsp)
    );

    // clamp configuration
    always_comb begin
        if (r_sector_bytes < SB_MIN) begin
            w_s_eff = SB_MIN;
        end else if (r_sector_bytes > SB_MAX) begin
            w_s_eff = SB_MAX;
        end else begin
            w_s_eff = r_sector_bytes;
        end
        if (r_sector_count < SC_MIN) begin
            w_n_eff = SC_MIN;
        end else if (r_sector_count > SC_MAX) begin
            w_n_eff = SC_MAX;
        end else begin
            w_n_eff = r_sector_count;
        end
    end

    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !o_valid || !i_stall;
    assign w_too_big  = r_size > w_s_eff;

    // placement from the end-sector quotient
    assign w_end      = NUM_W'(r_head) + NUM_W'(r_size) - NUM_W'(1);
    assign w_cross    = w_rsp.quot != r_wsec;
    assign w_sec0     = w_cross ? w_rsp.quot : r_wsec;
    assign w_off0     = w_cross ? (w_end - NUM_W'(w_rsp.rem)) : NUM_W'(r_head);
    assign w_wrap     = w_sec0 >= w_n_eff;
    assign w_sec      = w_wrap ? '0 : w_sec0;
    assign w_off      = w_wrap ? '0 : w_off0;
    assign w_erase    = w_wrap || (w_sec == QUOT_W'(r_tail) && r_tail_full);
    assign w_moved    = w_erase && (w_sec == QUOT_W'(r_tail));
    assign w_tail_inc = QUOT_W'(r_tail) + QUOT_W'(1);
    assign w_tail_nxt = w_moved ? ((w_tail_inc == w_n_eff) ? '0 : w_tail_inc[SEC_W-1:0])
                                : r_tail;
    assign w_head_new = HEAD_W'(w_off + NUM_W'(r_size));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = w_too_big ? ST_DONE : ST_DIV_W;
            end
            ST_DIV_W: begin
                if (w_rsp.done) begin
                    n_state = ST_DIV_E;
                end
            end
            ST_DIV_E: begin
                if (w_rsp.done) begin
                    n_state = ST_DIV_H;
                end
            end
            ST_DIV_H: begin
                if (w_rsp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // divider requests and input stall
    always_comb begin
        w_req.start = 1'b0;
        w_req.numer = NUM_W'(r_head);
        o_stall     = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_CHECK: begin
                w_req.start = !w_too_big;
                w_req.numer = NUM_W'(r_head);
            end
            ST_DIV_W: begin
                w_req.start = w_rsp.done;
                w_req.numer = w_end;
            end
            ST_DIV_E: begin
                w_req.start = w_rsp.done;
                w_req.numer = NUM_W'(w_head_new);
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sector_bytes <= SB_RESET;
            r_sector_count <= SC_RESET;
            r_head         <= '0;
            r_tail         <= '0;
            r_gen          <= 1'b0;
            r_tail_full    <= 1'b0;
            o_valid        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_SECTOR_BYTES: r_sector_bytes <= i_cfg_wdata;
                    REG_SECTOR_COUNT: r_sector_count <= i_cfg_wdata[SC_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_DIV_E && w_rsp.done) begin
                r_head <= w_head_new;
                r_tail <= w_tail_nxt;
                r_gen  <= r_gen ^ w_wrap;
            end
            if (r_state == ST_DIV_H && w_rsp.done && w_rsp.quot != QUOT_W'(r_tail)) begin
                r_tail_full <= 1'b1;
            end
            if (r_state == ST_DONE && w_out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_size <= SB_W'(i_payload_length) + SB_W'(HEADER_BYTES);
        end
        if (r_state == ST_CHECK) begin
            r_reject <= w_too_big;
        end
        if (r_state == ST_DIV_W && w_rsp.done) begin
            r_wsec <= w_rsp.quot;
        end
        if (r_state == ST_DIV_E && w_rsp.done) begin
            r_woff  <= w_off[OFF_W-1:0];
            r_sec   <= w_sec[SEC_W-1:0];
            r_erase <= w_erase;
            r_moved <= w_moved;
        end
        if (r_state == ST_DONE && w_out_free) begin
            o_accepted         <= !r_reject;
            o_place_offset     <= r_reject ? '0 : r_woff;
            o_erase_needed     <= !r_reject && r_erase;
            o_erase_index      <= (r_reject || !r_erase) ? '0 : r_sec;
            o_stamp_generation <= r_gen;
            o_oldest_sector    <= r_tail;
            o_tail_moved       <= !r_reject && r_moved;
        end
    end

endmodule

// ----- hw/rtl/cflwa_div.sv -----
`timescale 1ns / 1ps
module cflwa_div
    import cflwa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_div_req        i_req,
    input  logic [SB_W-1:0] i_divisor,
    output t_div_rsp        o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsh;
    logic [QUOT_W-1:0] r_quot;

    logic              w_ge;
    logic [NUM_W-1:0]  w_diff;

    assign w_ge   = r_rem >= r_dsh;
    assign w_diff = r_rem - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_TOP;
            end else if (r_busy) begin
                if (r_step == STEP_TOP && w_ge) begin
                    // quotient of 256 or more, saturate
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.numer;
            r_dsh  <= NUM_W'({i_divisor, 8'd0});
            r_quot <= '0;
        end else if (r_busy) begin
            if (r_step == STEP_TOP) begin
                if (w_ge) begin
                    r_quot <= QUOT_SAT;
                end
            end else if (w_ge) begin
                r_rem  <= w_diff;
                r_quot <= r_quot | (QUOT_W'(1) << r_step);
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem[SB_W-1:0];

endmodule

// ----- hw/rtl/cflwa_checker.sv -----
`timescale 1ns / 1ps
`include "circular_flash_log_write_allocator_assert.svh"
module cflwa_checker
    import cflwa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_accepted,
    input logic [OFF_W-1:0]     o_place_offset,
    input logic                 o_erase_needed,
    input logic [SEC_W-1:0]     o_erase_index,
    input logic                 o_tail_moved
);

    `CFLWA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_place_offset))

    `CFLWA_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    `CFLWA_ASSERT_IMP(a_reject_clean, i_clk, i_rst_n, o_valid && !o_accepted, o_place_offset == '0 && !o_erase_needed && !o_tail_moved)

    `CFLWA_ASSERT_IMP(a_index_gated, i_clk, i_rst_n, o_valid && !o_erase_needed, o_erase_index == '0)

    `CFLWA_ASSERT_IMP(a_move_erases, i_clk, i_rst_n, o_valid && o_tail_moved, o_erase_needed)

endmodule

bind circular_flash_log_write_allocator cflwa_checker u_cflwa_checker (.*);
